// File: rtl/numeric_field_extractor_core_defines.svh
// Assertion macros used by the extractor core.
`ifndef NUMERIC_FIELD_EXTRACTOR_CORE_DEFINES_SVH
`define NUMERIC_FIELD_EXTRACTOR_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define NFE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define NFE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/nfe_pkg.sv
package nfe_pkg;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UPA    = 8'h41;
    localparam logic [7:0] CH_UPZ    = 8'h5A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_HASH   = 8'h23;

    // Work for the back end produced by one input byte.
    typedef struct packed {
        logic       emit_held;
        logic [7:0] held;
        logic       emit_hash;
    } t_nfe_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_nfe_qstat;

endpackage

// File: rtl/numeric_field_extractor_core.sv
// Numeric field extractor.
// Input channel: i_valid / o_stall with i_in_byte and i_frame_end; a transfer
// happens on a clock edge with i_valid high and o_stall low. i_frame_end marks
// the last byte of a received frame.
// Output channel: o_valid / i_stall with o_out_byte and o_out_last; o_out_last
// flags the closing '#' of a rebuilt message.
// The front end takes one byte per cycle while the queue is not full and turns
// it into at most two output bytes, queued in a DEPTH-entry queue (DEPTH a power of two, at least 2).
// The back end sends one output byte per cycle, while the receiver does not stall, from a registered output.
// A byte that produces output is written into the queue when it transfers;
// the back end then loads it into the output register. Throughput: one input
// byte per cycle while output keeps up; a frame end that also copies a byte
// gives the back end two bytes to send, so sustained rate is set by the
// one-byte-per-cycle output.
// When the receiver stalls, output holds, the queue fills and o_stall rises
// once DEPTH entries wait. Reset (synchronous, active low) empties the queue,
// drops the output and clears the parser to its idle state.
module numeric_field_extractor_core
    import nfe_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_frame_end,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_byte,
    output logic       o_out_last
);

`include "numeric_field_extractor_core_defines.svh"

    localparam int CW = $clog2(DEPTH + 1);

    logic          accept;
    logic          push;
    logic          pop;
    t_nfe_entry    entry;
    t_nfe_entry    head;
    t_nfe_qstat    qstat;
    logic [CW-1:0] qcount;

    assign o_stall = qstat.full;
    assign accept  = i_valid && !qstat.full;

    nfe_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_in_byte   (i_in_byte),
        .i_frame_end (i_frame_end),
        .o_push      (push),
        .o_entry     (entry)
    );

    nfe_queue #(
        .DEPTH (DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (entry),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (qstat),
        .o_count (qcount)
    );

    nfe_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head),
        .i_qstat    (qstat),
        .o_pop      (pop),
        .i_stall    (i_stall),
        .o_valid    (o_valid),
        .o_out_byte (o_out_byte),
        .o_out_last (o_out_last)
    );

    `NFE_ASSERT_NOW(a_last_is_hash, o_valid,
        (o_out_last == (o_out_byte == CH_HASH)), "out_last does not match closing byte")
    `NFE_ASSERT_NEXT(a_msg_starts_dollar, o_valid && !i_stall && o_out_last,
        !o_valid || (o_out_byte == CH_DOLLAR), "message does not open with dollar")
    `NFE_ASSERT_NOW(a_queue_bound, 1'b1,
        (qcount <= CW'(DEPTH)) && !(push && qstat.full), "queue overflow")
    `NFE_ASSERT_NOW(a_no_pop_empty, pop, !qstat.empty, "pop from empty queue")

endmodule

// File: rtl/nfe_front.sv
module nfe_front
    import nfe_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_in_byte,
    input  logic       i_frame_end,
    output logic       o_push,
    output t_nfe_entry o_entry
);

    logic       r_armed, n_armed;
    logic       r_digits, n_digits;
    logic [7:0] r_held, n_held;
    logic       r_copied, n_copied;

    logic       is_colon, is_digit, is_word, is_sep;
    logic       append;
    logic [7:0] append_byte;

    always_comb begin
        is_colon = (i_in_byte == CH_COLON);
        is_digit = (i_in_byte >= CH_ZERO) && (i_in_byte <= CH_NINE);
        is_word  = ((i_in_byte >= CH_UPA) && (i_in_byte <= CH_UPZ)) ||
                   (i_in_byte == CH_COMMA);
        is_sep   = (i_in_byte == CH_SPACE) || (i_in_byte == CH_NL);

        append = r_armed && !is_colon &&
                 (is_digit || (r_digits && (is_word || is_sep)));
        append_byte = (is_sep) ? CH_SEMI : i_in_byte;

        n_armed  = r_armed;
        n_digits = r_digits;
        n_held   = append ? append_byte : r_held;
        n_copied = r_copied || append;

        if (is_colon) begin
            n_armed = 1'b1;
        end else if (r_armed) begin
            if (is_digit) begin
                n_digits = 1'b1;
            end else if (is_sep && r_digits) begin
                n_armed  = 1'b0;
                n_digits = 1'b0;
            end else if (i_in_byte == CH_NL) begin
                n_armed = 1'b0;
            end
        end

        o_entry.emit_held = append;
        o_entry.held      = r_held;
        o_entry.emit_hash = i_frame_end && n_copied;
        o_push = i_accept && (o_entry.emit_held || o_entry.emit_hash);

        // close the frame: drop the held byte and start over
        if (i_frame_end) begin
            n_armed  = 1'b0;
            n_digits = 1'b0;
            n_held   = CH_DOLLAR;
            n_copied = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed  <= 1'b0;
            r_digits <= 1'b0;
            r_held   <= CH_DOLLAR;
            r_copied <= 1'b0;
        end else if (i_accept) begin
            r_armed  <= n_armed;
            r_digits <= n_digits;
            r_held   <= n_held;
            r_copied <= n_copied;
        end
    end

endmodule

// File: rtl/nfe_queue.sv
module nfe_queue
    import nfe_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  t_nfe_entry                 i_entry,
    input  logic                       i_pop,
    output t_nfe_entry                 o_head,
    output t_nfe_qstat                 o_stat,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_nfe_entry      r_mem [DEPTH];
    logic [PW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]   r_count;

    // DEPTH is a power of two, so the pointers wrap on their own
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_head       = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == CW'(DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_count      = r_count;

endmodule

// File: rtl/nfe_back.sv
module nfe_back
    import nfe_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_nfe_entry i_head,
    input  t_nfe_qstat i_qstat,
    output logic       o_pop,
    input  logic       i_stall,
    output logic       o_valid,
    output logic [7:0] o_out_byte,
    output logic       o_out_last
);

    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_last;
    logic       r_held_done;   // held byte of the head entry already sent
    logic       load;
    logic       send_held;

    assign load      = !i_qstat.empty && (!r_valid || !i_stall);
    assign send_held = i_head.emit_held && !r_held_done;
    // retire the entry once its final byte is loaded
    assign o_pop     = load && !(send_held && i_head.emit_hash);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_held_done <= 1'b0;
        end else begin
            if (load) begin
                r_valid     <= 1'b1;
                r_held_done <= send_held && i_head.emit_hash;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= send_held ? i_head.held : CH_HASH;
            r_last <= !send_held;
        end
    end

    assign o_valid    = r_valid;
    assign o_out_byte = r_byte;
    assign o_out_last = r_last;

endmodule
